// ===== sv/rsi_pkg.sv =====
// Shared widths and types for the ray-sphere intersection pipeline.
package rsi_pkg;

    localparam int CW     = 32;   // coordinate width, Q16.16
    localparam int R_W    = 31;   // radius width
    localparam int W_W    = 33;   // center minus origin
    localparam int WV_W   = 65;   // w*v product
    localparam int WSQ_W  = 65;   // w*w product (non-negative)
    localparam int VSQ_W  = 63;   // v*v product (non-negative)
    localparam int R2_W   = 62;   // r*r
    localparam int B_W    = 66;   // b = w.v, signed
    localparam int BM_W   = 65;   // |b|
    localparam int E_W    = 67;   // w.w - r*r, signed
    localparam int EM_W   = 66;   // |w.w - r*r|
    localparam int VV_W   = 64;   // v.v
    localparam int PR_W   = 131;  // b*b and |e|*vv
    localparam int RAD_W  = 130;  // non-negative discriminant
    localparam int ROOT_W = 65;   // floor(sqrt(disc))
    localparam int NU_W   = 67;   // b - sqrt, signed
    localparam int NM_W   = 66;   // |b - sqrt|
    localparam int P_W    = 98;   // |v_i * (b - sqrt)|
    localparam int Q_W    = 33;   // quotient bits kept before saturation
    localparam int NLANE  = 3;    // x, y, z

    // side data riding alongside the wide multipliers
    typedef struct packed {
        logic signed [B_W-1:0]      b;
        logic [VV_W-1:0]            vv;
        logic [NLANE-1:0][CW-1:0]   vmag;
        logic [NLANE-1:0]           vneg;
        logic                       eneg;
    } t_sa;

    // side data riding alongside the square root
    typedef struct packed {
        logic signed [B_W-1:0]      b;
        logic [VV_W-1:0]            vv;
        logic [NLANE-1:0][CW-1:0]   vmag;
        logic [NLANE-1:0]           vneg;
        logic                       hit;
    } t_sb;

    // side data riding alongside the final products
    typedef struct packed {
        logic [VV_W-1:0]            vv;
        logic [NLANE-1:0]           pneg;
        logic                       hit;
        logic                       zero;
    } t_sc;

    // side data riding alongside the divider
    typedef struct packed {
        logic [NLANE-1:0]           pneg;
        logic                       hit;
        logic                       zero;
    } t_sd;

    typedef struct packed {
        logic signed [CW-1:0]       hit_x;
        logic signed [CW-1:0]       hit_y;
        logic signed [CW-1:0]       hit_z;
        logic                       hit;
    } t_res;

endpackage

// ===== sv/rsi_if.sv =====
// Valid/ready channel interfaces for ray input and hit result.
interface rsi_in_if import rsi_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [R_W-1:0]       radius;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, radius,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, radius,
        output ready
    );
endinterface

interface rsi_out_if import rsi_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
    logic                 hit;

    modport source (output valid, hit_x, hit_y, hit_z, hit, input ready);
    modport sink (input valid, hit_x, hit_y, hit_z, hit, output ready);
endinterface

// ===== sv/rsi_dly.sv =====
// Delay line with valid bits, stepping with the pipeline enable.
module rsi_dly #(
    parameter int DEPTH = 4,
    parameter int W     = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_data [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

// ===== sv/rsi_mul.sv =====
// Pipelined unsigned multiplier: one stage per digit of the B operand.
module rsi_mul #(
    parameter int AW = 66,
    parameter int BW = 65,
    parameter int DW = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int NC  = (BW + DW - 1) / DW;
    localparam int PW  = AW + BW;
    localparam int BPW = NC * DW;

    logic [AW-1:0]  a_in   [NC];
    logic [BPW-1:0] b_in   [NC];
    logic [PW-1:0]  acc_in [NC];
    logic [PW-1:0]  r_acc  [NC];

    assign a_in[0]   = i_a;
    assign b_in[0]   = BPW'(i_b);
    assign acc_in[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_stage
        logic [AW+DW-1:0] pp;

        assign pp = a_in[k] * b_in[k][DW-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= acc_in[k] + (PW'(pp) << (k * DW));
            end
        end

        if (k < NC - 1) begin : g_pass
            logic [AW-1:0]  r_a;
            logic [BPW-1:0] r_b;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a <= a_in[k];
                    r_b <= b_in[k] >> DW;
                end
            end

            assign a_in[k+1]   = r_a;
            assign b_in[k+1]   = r_b;
            assign acc_in[k+1] = r_acc[k];
        end
    end

    assign o_p = r_acc[NC-1];

endmodule

// ===== sv/rsi_sqrt.sv =====
// Pipelined integer square root: one root bit resolved per stage.
module rsi_sqrt #(
    parameter int NW = 130
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NW-1:0]     i_rad,
    output logic [NW/2-1:0]   o_root
);

    localparam int RW = NW / 2;

    logic [NW-1:0]   rad_in  [RW];
    logic [RW+1:0]   rem_in  [RW];
    logic [RW-1:0]   root_in [RW];
    logic [RW-1:0]   r_root  [RW];

    assign rad_in[0]  = i_rad;
    assign rem_in[0]  = '0;
    assign root_in[0] = '0;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;

        // bring down the next two radicand bits, try root*4+1
        assign cur   = {rem_in[k], rad_in[k][NW-1 -: 2]};
        assign trial = {2'b00, root_in[k], 2'b01};
        assign diff  = cur - trial;
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {root_in[k][RW-2:0], ge};
            end
        end

        if (k < RW - 1) begin : g_pass
            logic [NW-1:0] r_rad;
            logic [RW+1:0] r_rem;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad <= rad_in[k] << 2;
                    r_rem <= ge ? diff[RW+1:0] : cur[RW+1:0];
                end
            end

            assign rad_in[k+1]  = r_rad;
            assign rem_in[k+1]  = r_rem;
            assign root_in[k+1] = r_root[k];
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== sv/rsi_div.sv =====
// Pipelined restoring divider, several lanes sharing one divisor.
// Keeps QW quotient bits and flags quotients of 2**QW or more.
module rsi_div #(
    parameter int NW = 98,
    parameter int DW = 64,
    parameter int QW = 33,
    parameter int NL = 3
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num [NL],
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo [NL],
    output logic          o_big [NL]
);

    localparam int HW = NW - QW;

    logic [DW-1:0] r_den [QW];
    logic [DW-1:0] r_rem [QW][NL];
    logic [QW-1:0] r_lo  [QW][NL];
    logic [QW-1:0] r_quo [QW][NL];
    logic          r_big [QW+1][NL];

    // first stage: overflow check on the high part, seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int l = 0; l < NL; l++) begin
                r_big[0][l] <= i_num[l][NW-1:QW] >= HW'(i_den);
                r_rem[0][l] <= i_num[l][QW+DW-1:QW];
                r_lo[0][l]  <= i_num[l][QW-1:0];
            end
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        if (k < QW) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= r_den[k-1];
                end
            end
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [QW-1:0] quo_in;
            logic [DW:0]   cur;
            logic [DW:0]   diff;
            logic          ge;

            if (k == 1) begin : g_q0
                assign quo_in = '0;
            end else begin : g_qn
                assign quo_in = r_quo[k-2][l];
            end

            assign cur  = {r_rem[k-1][l], r_lo[k-1][l][QW-1]};
            assign diff = cur - {1'b0, r_den[k-1]};
            assign ge   = cur >= {1'b0, r_den[k-1]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[k-1][l] <= {quo_in[QW-2:0], ge};
                    r_big[k][l]   <= r_big[k-1][l];
                end
            end

            if (k < QW) begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k][l] <= ge ? diff[DW-1:0] : cur[DW-1:0];
                        r_lo[k][l]  <= r_lo[k-1][l] << 1;
                    end
                end
            end
        end
    end

    for (genvar l = 0; l < NL; l++) begin : g_out
        assign o_quo[l] = r_quo[QW-1][l];
        assign o_big[l] = r_big[QW][l];
    end

endmodule

// ===== sv/ray_sphere_intersection.sv =====
// Ray-sphere intersection: fully pipelined, one ray-sphere pair per cycle while
// i_ray.ready is high. The 65-stage square root and 34-stage divider make up most
// of the pipeline depth.
// Throughput: one transaction per cycle while the skid entry is empty; a two-entry
// output register/skid stage lets the pipeline keep taking rays while one result waits.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are not reset.
module ray_sphere_intersection import rsi_pkg::*; #(
    parameter int MUL_DIG_W = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsi_in_if.sink     i_ray,
    rsi_out_if.source  o_res
);

    localparam int LAT_M1 = (BM_W + MUL_DIG_W - 1) / MUL_DIG_W;
    localparam int LAT_M2 = (CW + MUL_DIG_W - 1) / MUL_DIG_W;

    function automatic logic [CW-1:0] sat_q(input logic [Q_W-1:0] q,
                                            input logic big, input logic neg);
        logic [CW-1:0] r;
        if (!neg) begin
            r = (big || q[Q_W-1] || q[Q_W-2]) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
        end else begin
            r = (big || q[Q_W-1] || (q[Q_W-2] && (q[Q_W-3:0] != '0))) ?
                {1'b1, {(CW-1){1'b0}}} : (~q[CW-1:0] + CW'(1));
        end
        return r;
    endfunction

    logic en;
    logic r_skid_valid;
    assign en          = !r_skid_valid;
    assign i_ray.ready = en;

    logic signed [CW-1:0] in_o [NLANE];
    logic signed [CW-1:0] in_d [NLANE];
    logic signed [CW-1:0] in_c [NLANE];
    assign in_o[0] = i_ray.origin_x;
    assign in_o[1] = i_ray.origin_y;
    assign in_o[2] = i_ray.origin_z;
    assign in_d[0] = i_ray.dir_x;
    assign in_d[1] = i_ray.dir_y;
    assign in_d[2] = i_ray.dir_z;
    assign in_c[0] = i_ray.center_x;
    assign in_c[1] = i_ray.center_y;
    assign in_c[2] = i_ray.center_z;

    // ---- stage 1: w = c - o
    logic signed [W_W-1:0] r_w  [NLANE];
    logic signed [CW-1:0]  r_dv [NLANE];
    logic [R_W-1:0]        r_rad;
    logic                  r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_ray.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NLANE; i++) begin
                r_w[i]  <= W_W'(in_c[i]) - W_W'(in_o[i]);
                r_dv[i] <= in_d[i];
            end
            r_rad <= i_ray.radius;
        end
    end

    // ---- stage 2: per-axis products
    logic signed [2*W_W-1:0] n_wsq [NLANE];
    logic signed [2*CW-1:0]  n_vsq [NLANE];
    logic signed [WV_W-1:0]  r_wv  [NLANE];
    logic [WSQ_W-1:0]        r_wsq [NLANE];
    logic [VSQ_W-1:0]        r_vsq [NLANE];
    logic [R2_W-1:0]         r_r2;
    logic [CW-1:0]           r_vmag2 [NLANE];
    logic [NLANE-1:0]        r_vneg2;
    logic                    r_v2;

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            n_wsq[i] = r_w[i] * r_w[i];
            n_vsq[i] = r_dv[i] * r_dv[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NLANE; i++) begin
                r_wv[i]    <= r_w[i] * r_dv[i];
                r_wsq[i]   <= n_wsq[i][WSQ_W-1:0];
                r_vsq[i]   <= n_vsq[i][VSQ_W-1:0];
                r_vneg2[i] <= r_dv[i][CW-1];
                r_vmag2[i] <= r_dv[i][CW-1] ? (~r_dv[i] + CW'(1)) : r_dv[i];
            end
            r_r2 <= r_rad * r_rad;
        end
    end

    // ---- stage 3: dot products
    logic signed [B_W-1:0] r_b3;
    logic [E_W-1:0]        r_e3;
    logic [VV_W-1:0]       r_vv3;
    logic [CW-1:0]         r_vmag3 [NLANE];
    logic [NLANE-1:0]      r_vneg3;
    logic                  r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b3  <= B_W'(r_wv[0]) + B_W'(r_wv[1]) + B_W'(r_wv[2]);
            r_e3  <= E_W'(r_wsq[0]) + E_W'(r_wsq[1]) + E_W'(r_wsq[2]) - E_W'(r_r2);
            r_vv3 <= VV_W'(r_vsq[0]) + VV_W'(r_vsq[1]) + VV_W'(r_vsq[2]);
            r_vmag3 <= r_vmag2;
            r_vneg3 <= r_vneg2;
        end
    end

    // ---- stage 4: magnitudes for the wide multipliers
    logic [BM_W-1:0]       r_bm;
    logic [EM_W-1:0]       r_em;
    logic signed [B_W-1:0] neg_b3;
    logic [E_W-1:0]        neg_e3;
    t_sa                   r_sa;
    logic                  r_v4;

    assign neg_b3 = -r_b3;
    assign neg_e3 = -r_e3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bm      <= r_b3[B_W-1] ? neg_b3[BM_W-1:0] : r_b3[BM_W-1:0];
            r_em      <= r_e3[E_W-1] ? neg_e3[EM_W-1:0] : r_e3[EM_W-1:0];
            r_sa.b    <= r_b3;
            r_sa.vv   <= r_vv3;
            r_sa.eneg <= r_e3[E_W-1];
            r_sa.vneg <= r_vneg3;
            for (int i = 0; i < NLANE; i++) begin
                r_sa.vmag[i] <= r_vmag3[i];
            end
        end
    end

    // ---- b*b and |e|*vv
    logic [PR_W-1:0] b2;
    logic [PR_W-1:0] ev;
    t_sa             sa_d;
    logic            va_d;

    rsi_mul #(.AW(EM_W), .BW(BM_W), .DW(MUL_DIG_W)) u_mul_bb (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   ({1'b0, r_bm}),
        .i_b   (r_bm),
        .o_p   (b2)
    );

    rsi_mul #(.AW(EM_W), .BW(BM_W), .DW(MUL_DIG_W)) u_mul_ev (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_em),
        .i_b   ({1'b0, r_sa.vv}),
        .o_p   (ev)
    );

    rsi_dly #(.DEPTH(LAT_M1), .W($bits(t_sa))) u_dly_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v4),
        .i_data  (r_sa),
        .o_valid (va_d),
        .o_data  (sa_d)
    );

    // ---- discriminant; a miss feeds zero to the root
    logic [PR_W-1:0]  n_disc;
    logic [RAD_W-1:0] r_disc;
    t_sb              r_sb;
    logic             r_v5;

    assign n_disc = sa_d.eneg ? (b2 + ev) : (b2 - ev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= va_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_disc    <= n_disc[PR_W-1] ? '0 : n_disc[RAD_W-1:0];
            r_sb.b    <= sa_d.b;
            r_sb.vv   <= sa_d.vv;
            r_sb.vmag <= sa_d.vmag;
            r_sb.vneg <= sa_d.vneg;
            r_sb.hit  <= !n_disc[PR_W-1];
        end
    end

    // ---- square root
    logic [ROOT_W-1:0] root;
    t_sb               sb_d;
    logic              vb_d;

    rsi_sqrt #(.NW(RAD_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_disc),
        .o_root (root)
    );

    rsi_dly #(.DEPTH(ROOT_W), .W($bits(t_sb))) u_dly_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v5),
        .i_data  (r_sb),
        .o_valid (vb_d),
        .o_data  (sb_d)
    );

    // ---- b - sqrt(disc), as sign and magnitude
    logic [NU_W-1:0] nu_d1;
    logic [NU_W-1:0] nu_d2;
    logic [NM_W-1:0] r_nmag;
    logic [CW-1:0]   r_vmag6 [NLANE];
    t_sc             r_sc;
    logic            r_v6;

    assign nu_d1 = NU_W'(sb_d.b) - NU_W'(root);
    assign nu_d2 = NU_W'(root) - NU_W'(sb_d.b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= vb_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nmag    <= nu_d1[NU_W-1] ? nu_d2[NM_W-1:0] : nu_d1[NM_W-1:0];
            r_sc.vv   <= sb_d.vv;
            r_sc.hit  <= sb_d.hit;
            r_sc.zero <= !sb_d.hit || (sb_d.vv == '0);
            for (int i = 0; i < NLANE; i++) begin
                r_vmag6[i]   <= sb_d.vmag[i];
                r_sc.pneg[i] <= nu_d1[NU_W-1] ^ sb_d.vneg[i];
            end
        end
    end

    // ---- v_i * (b - sqrt)
    logic [P_W-1:0] prod [NLANE];
    t_sc            sc_d;
    logic           vc_d;

    for (genvar i = 0; i < NLANE; i++) begin : g_lane
        rsi_mul #(.AW(NM_W), .BW(CW), .DW(MUL_DIG_W)) u_mul_p (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_nmag),
            .i_b   (r_vmag6[i]),
            .o_p   (prod[i])
        );
    end

    rsi_dly #(.DEPTH(LAT_M2), .W($bits(t_sc))) u_dly_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v6),
        .i_data  (r_sc),
        .o_valid (vc_d),
        .o_data  (sc_d)
    );

    // ---- divide by v.v
    logic [Q_W-1:0] quo [NLANE];
    logic           big [NLANE];
    t_sd            sd_in;
    t_sd            sd_d;
    logic           vd_d;

    assign sd_in.pneg = sc_d.pneg;
    assign sd_in.hit  = sc_d.hit;
    assign sd_in.zero = sc_d.zero;

    rsi_div #(.NW(P_W), .DW(VV_W), .QW(Q_W), .NL(NLANE)) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (prod),
        .i_den (sc_d.vv),
        .o_quo (quo),
        .o_big (big)
    );

    rsi_dly #(.DEPTH(Q_W + 1), .W($bits(t_sd))) u_dly_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vc_d),
        .i_data  (sd_in),
        .o_valid (vd_d),
        .o_data  (sd_d)
    );

    // ---- sign and saturate
    t_res          r_end;
    logic          r_vend;
    logic [CW-1:0] n_hv [NLANE];

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            n_hv[i] = sd_d.zero ? '0 : sat_q(quo[i], big[i], sd_d.pneg[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vend <= 1'b0;
        end else if (en) begin
            r_vend <= vd_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_end.hit_x <= n_hv[0];
            r_end.hit_y <= n_hv[1];
            r_end.hit_z <= n_hv[2];
            r_end.hit   <= sd_d.hit;
        end
    end

    // ---- output register with skid entry
    t_res r_out;
    t_res r_skid;
    t_res n_out;
    t_res n_skid;
    logic r_out_valid;
    logic n_out_valid;
    logic n_skid_valid;
    logic out_take;

    assign out_take = r_out_valid && o_res.ready;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (out_take || !r_out_valid) begin
            n_out_valid = r_vend;
            n_out       = r_end;
        end else if (r_vend) begin
            n_skid_valid = 1'b1;
            n_skid       = r_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.hit_x = r_out.hit_x;
    assign o_res.hit_y = r_out.hit_y;
    assign o_res.hit_z = r_out.hit_z;
    assign o_res.hit   = r_out.hit;

endmodule
